/* rtl/core/ipv4rc_pkg.sv */
package ipv4rc_pkg;

    localparam int unsigned DataWidth     = 8;
    localparam int unsigned AddrWidth     = 32;
    localparam int unsigned CountWidth    = 6;
    localparam int unsigned SumWidth      = 21;
    localparam int unsigned ResultBits    = 65;
    localparam int unsigned ResultWidth   = 72;

    localparam logic [CountWidth-1:0] CountMax     = 6'd63;
    localparam logic [CountWidth-1:0] MinHeader    = 6'd20;
    localparam logic [3:0]            IpVersion    = 4'd4;

    localparam logic [CountWidth-1:0] PosTotalHi   = 6'd2;
    localparam logic [CountWidth-1:0] PosTotalLo   = 6'd3;
    localparam logic [CountWidth-1:0] PosProtocol  = 6'd9;
    localparam logic [CountWidth-1:0] PosSumHi     = 6'd10;
    localparam logic [CountWidth-1:0] PosSumLo     = 6'd11;
    localparam logic [CountWidth-1:0] PosSrcFirst  = 6'd12;
    localparam logic [CountWidth-1:0] PosSrcLast   = 6'd15;
    localparam logic [CountWidth-1:0] PosDstFirst  = 6'd16;
    localparam logic [CountWidth-1:0] PosDstLast   = 6'd19;

    localparam logic [7:0] ProtoIcmp = 8'd1;
    localparam logic [7:0] ProtoTcp  = 8'd6;
    localparam logic [7:0] ProtoUdp  = 8'd17;

    typedef enum logic [2:0] {
        STATUS_ICMP      = 3'd0,
        STATUS_UDP       = 3'd1,
        STATUS_TCP       = 3'd2,
        STATUS_SHORT     = 3'd3,
        STATUS_BAD_HDR   = 3'd4,
        STATUS_BAD_SUM   = 3'd5,
        STATUS_NOT_OURS  = 3'd6,
        STATUS_UNKNOWN   = 3'd7
    } status_t;

endpackage

/* rtl/core/ipv4_header_receive_check_core.sv */
// IPv4 header receive check.
// The slave stream carries a packet one byte per item in s_tdata, header first in
// network order, with s_tlast set on the final byte. Each byte updates a byte counter,
// the latched header fields and a running sum of the header words. On the final byte
// one verdict item leaves on the master stream: status, protocol number, source
// address, payload length and header length in bytes.
// The local address is written through cfg_we and cfg_wdata; the user must do so only
// while the block is idle, which the block itself does not enforce. An accepted byte is
// held in an input register and then folded into the packet state; a final byte loads
// the verdict register, which drives m_tvalid. One byte is taken every cycle while
// s_tready is high. When the receiver stalls, the verdict waits in its register; bytes
// of the next packet are still taken, and only a final byte waiting behind an untaken
// verdict holds the input register and lowers s_tready.
// Reset clears the local address, the packet state and both valid flags.
module ipv4_header_receive_check_core
    import ipv4rc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [DataWidth-1:0]   s_tdata,   // data_byte
    input  logic                   s_tlast,   // last_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // status [2:0], protocol_number [10:3], source_address [42:11],
    // payload_length [58:43], header_bytes [64:59], zero fill above
    output logic [ResultWidth-1:0] m_tdata,
    input  logic                   cfg_we,
    input  logic [AddrWidth-1:0]   cfg_wdata
);

    logic                  in_valid_reg;
    logic [DataWidth-1:0]  in_data_reg;
    logic                  in_last_reg;
    logic                  advance;

    logic [AddrWidth-1:0]  local_address_reg;

    logic [CountWidth-1:0] byte_count_reg, byte_count_next;
    logic [SumWidth-1:0]   word_sum_reg, word_sum_next;
    logic [7:0]            high_byte_hold_reg, high_byte_hold_next;
    logic [7:0]            version_and_length_reg, version_and_length_next;
    logic [15:0]           total_length_reg, total_length_next;
    logic [7:0]            protocol_reg, protocol_next;
    logic [15:0]           stored_sum_reg, stored_sum_next;
    logic [31:0]           source_reg, source_next;
    logic [31:0]           destination_reg, destination_next;

    logic                  out_valid_reg;
    logic [ResultWidth-1:0] out_data_reg;

    logic [CountWidth-1:0] pos;
    logic [7:0]            vl_cur;
    logic [CountWidth-1:0] hdr_len_cur;
    logic [CountWidth-1:0] header_bytes;
    logic [3:0]            version;
    logic [16:0]           fold_one;
    logic [16:0]           fold_two;
    logic [15:0]           calc_sum;
    status_t               status;
    logic [15:0]           payload_length;

    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign pos         = byte_count_reg;
    assign vl_cur      = (pos == '0) ? in_data_reg : version_and_length_reg;
    assign hdr_len_cur = {vl_cur[3:0], 2'b00};

    always_comb
    begin
        byte_count_next         = byte_count_reg;
        word_sum_next           = word_sum_reg;
        high_byte_hold_next     = high_byte_hold_reg;
        version_and_length_next = version_and_length_reg;
        total_length_next       = total_length_reg;
        protocol_next           = protocol_reg;
        stored_sum_next         = stored_sum_reg;
        source_next             = source_reg;
        destination_next        = destination_reg;
        if (pos != CountMax)
        begin
            version_and_length_next = vl_cur;
            if (pos < hdr_len_cur)
            begin
                if (!pos[0])
                begin
                    high_byte_hold_next = in_data_reg;
                end
                else if (pos != PosSumLo)
                begin
                    word_sum_next = word_sum_reg
                                  + {5'd0, high_byte_hold_reg, in_data_reg};
                end
            end
            if (pos == PosTotalHi || pos == PosTotalLo)
            begin
                total_length_next = {total_length_reg[7:0], in_data_reg};
            end
            else if (pos == PosProtocol)
            begin
                protocol_next = in_data_reg;
            end
            else if (pos == PosSumHi || pos == PosSumLo)
            begin
                stored_sum_next = {stored_sum_reg[7:0], in_data_reg};
            end
            else if (pos >= PosSrcFirst && pos <= PosSrcLast)
            begin
                source_next = {source_reg[23:0], in_data_reg};
            end
            else if (pos >= PosDstFirst && pos <= PosDstLast)
            begin
                destination_next = {destination_reg[23:0], in_data_reg};
            end
            byte_count_next = pos + 6'd1;
        end
    end

    assign header_bytes   = {version_and_length_next[3:0], 2'b00};
    assign version        = version_and_length_next[7:4];
    assign fold_one       = {1'b0, word_sum_next[15:0]} + {12'd0, word_sum_next[20:16]};
    assign fold_two       = {1'b0, fold_one[15:0]} + {16'd0, fold_one[16]};
    assign calc_sum       = ~fold_two[15:0];
    assign payload_length = total_length_next - {10'd0, header_bytes};

    always_comb
    begin
        if (byte_count_next < MinHeader || byte_count_next < header_bytes)
        begin
            status = STATUS_SHORT;
        end
        else if (version != IpVersion || header_bytes < MinHeader)
        begin
            status = STATUS_BAD_HDR;
        end
        else if (calc_sum != stored_sum_next)
        begin
            status = STATUS_BAD_SUM;
        end
        else if (destination_next != local_address_reg)
        begin
            status = STATUS_NOT_OURS;
        end
        else
        begin
            case (protocol_next)
                ProtoIcmp: status = STATUS_ICMP;
                ProtoUdp:  status = STATUS_UDP;
                ProtoTcp:  status = STATUS_TCP;
                default:   status = STATUS_UNKNOWN;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            in_last_reg  <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
            in_last_reg  <= s_tlast;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready)
        begin
            in_data_reg <= s_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_address_reg <= '0;
        end
        else if (cfg_we)
        begin
            local_address_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg         <= '0;
            word_sum_reg           <= '0;
            high_byte_hold_reg     <= '0;
            version_and_length_reg <= '0;
            total_length_reg       <= '0;
            protocol_reg           <= '0;
            stored_sum_reg         <= '0;
            source_reg             <= '0;
            destination_reg        <= '0;
        end
        else if (advance)
        begin
            if (in_last_reg)
            begin
                byte_count_reg         <= '0;
                word_sum_reg           <= '0;
                high_byte_hold_reg     <= '0;
                version_and_length_reg <= '0;
                total_length_reg       <= '0;
                protocol_reg           <= '0;
                stored_sum_reg         <= '0;
                source_reg             <= '0;
                destination_reg        <= '0;
            end
            else
            begin
                byte_count_reg         <= byte_count_next;
                word_sum_reg           <= word_sum_next;
                high_byte_hold_reg     <= high_byte_hold_next;
                version_and_length_reg <= version_and_length_next;
                total_length_reg       <= total_length_next;
                protocol_reg           <= protocol_next;
                stored_sum_reg         <= stored_sum_next;
                source_reg             <= source_next;
                destination_reg        <= destination_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_data_reg <= {{(ResultWidth - ResultBits){1'b0}}, header_bytes,
                             payload_length, source_next, protocol_next, status};
        end
    end

`ifndef SYNTHESIS
    a_clear_state: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg == '0 |-> word_sum_reg == '0 && source_reg == '0
                                 && destination_reg == '0)
        else $error("packet state not cleared at the start of a packet");

    a_verdict_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(in_valid_reg && in_last_reg))
        else $error("verdict raised without a final byte");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && in_last_reg && out_valid_reg && !m_tready)
        else $error("input stalled without a waiting verdict");

    a_header_checked: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[2:0] == STATUS_ICMP || m_tdata[2:0] == STATUS_UDP
                     || m_tdata[2:0] == STATUS_TCP || m_tdata[2:0] == STATUS_UNKNOWN)
        |-> m_tdata[64:59] >= MinHeader)
        else $error("accepted packet with a header shorter than the minimum");
`endif

endmodule
